// ===== hdl/assert_macros.svh =====
// Assertion macros for the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on the rising clock edge, off during reset.
`define AST_IMPLY(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, sampled on the rising clock edge, off during reset.
`define AST_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== hdl/itoar_pkg.sv =====
// ----------------------------------------------------------------------------
// itoar_pkg
// Shared types, constants and the digit-to-character mapping for the
// integer to ASCII radix converter.
// ----------------------------------------------------------------------------
package itoar_pkg;

	localparam int RADIX_W   = 6;
	localparam int CHAR_W    = 8;
	localparam int STEP_BITS = 4;   // quotient bits resolved per divider cycle
	localparam int JOB_DEPTH = 2;   // front-to-back queue, power of two
	localparam int OUT_DEPTH = 4;   // result queue, power of two
	localparam int OUT_LW    = $clog2(OUT_DEPTH + 1);

	localparam logic [RADIX_W-1:0] RADIX_MIN = 6'd2;
	localparam logic [RADIX_W-1:0] RADIX_MAX = 6'd36;
	localparam logic [RADIX_W-1:0] DEC_BASE  = 6'd10;
	localparam logic [CHAR_W-1:0]  CHAR_ZERO = 8'h30;
	localparam logic [CHAR_W-1:0]  CHAR_A    = 8'h41;
	localparam logic [CHAR_W-1:0]  CHAR_NUL  = 8'h00;

	typedef struct packed {
		logic               bad;
		logic [RADIX_W-1:0] radix;
	} job_ctl_t;

	typedef struct packed {
		logic [CHAR_W-1:0] digit_char;
		logic              last_digit;
		logic              bad_radix;
	} out_item_t;

	function automatic logic [CHAR_W-1:0] digit_to_ascii(input logic [RADIX_W-1:0] d);
		logic [CHAR_W-1:0] dx;
		dx = {{(CHAR_W-RADIX_W){1'b0}}, d};
		if (d < DEC_BASE) begin
			return dx + CHAR_ZERO;
		end else begin
			return dx - {{(CHAR_W-RADIX_W){1'b0}}, DEC_BASE} + CHAR_A;
		end
	endfunction

endpackage

// ===== hdl/itoar_fifo.sv =====
// ----------------------------------------------------------------------------
// itoar_fifo
// Small register queue with a fill level. DEPTH must be a power of two.
// ----------------------------------------------------------------------------
module itoar_fifo #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 2
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         push,
	input  logic [WIDTH-1:0]             wdata,
	input  logic                         pop,
	output logic [WIDTH-1:0]             rdata,
	output logic                         empty,
	output logic [$clog2(DEPTH+1)-1:0]   level
);

	localparam int AW = $clog2(DEPTH);
	localparam int LW = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [AW-1:0]    wr_ptr_q;
	logic [AW-1:0]    rd_ptr_q;
	logic [LW-1:0]    level_q;
	logic             do_push;
	logic             do_pop;

	assign empty   = (level_q == '0);
	assign level   = level_q;
	assign rdata   = mem_q[rd_ptr_q];
	assign do_push = push && (level_q != LW'(DEPTH));
	assign do_pop  = pop && !empty;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			level_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				level_q <= level_q + 1'b1;
			end else if (!do_push && do_pop) begin
				level_q <= level_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= wdata;
		end
	end

endmodule

// ===== hdl/itoar_front.sv =====
// ----------------------------------------------------------------------------
// itoar_front
// Accepts items, flags an out-of-range radix, and queues them for the back end.
// ----------------------------------------------------------------------------
module itoar_front #(
	parameter int VALUE_WIDTH = 31
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            push,
	output logic                            full,
	input  logic [VALUE_WIDTH-1:0]          number,
	input  logic [itoar_pkg::RADIX_W-1:0]   radix,
	output logic                            job_valid,
	input  logic                            job_pop,
	output logic [VALUE_WIDTH-1:0]          job_number,
	output itoar_pkg::job_ctl_t             job_ctl
);
	import itoar_pkg::*;

	localparam int JW  = VALUE_WIDTH + $bits(job_ctl_t);
	localparam int JLW = $clog2(JOB_DEPTH + 1);

	job_ctl_t       ctl_in;
	logic [JW-1:0]  job_rdata;
	logic           job_empty;
	logic [JLW-1:0] job_level;

	// Classify the radix on the way in.
	always_comb begin
		ctl_in.radix = radix;
		ctl_in.bad   = (radix < RADIX_MIN) || (radix > RADIX_MAX);
	end

	assign full = (job_level == JLW'(JOB_DEPTH));

	itoar_fifo #(
		.WIDTH(JW),
		.DEPTH(JOB_DEPTH)
	) u_job_q (
		.clk   (clk),
		.arst_n(arst_n),
		.push  (push && !full),
		.wdata ({number, ctl_in}),
		.pop   (job_pop),
		.rdata (job_rdata),
		.empty (job_empty),
		.level (job_level)
	);

	assign job_valid  = !job_empty;
	assign job_number = job_rdata[JW-1 -: VALUE_WIDTH];
	assign job_ctl    = job_ctl_t'(job_rdata[$bits(job_ctl_t)-1:0]);

endmodule

// ===== hdl/itoar_back.sv =====
// ----------------------------------------------------------------------------
// itoar_back
// Digit engine: iterative divider producing digits least significant first
// into a digit stack, then reads the stack back out most significant first.
// ----------------------------------------------------------------------------
module itoar_back #(
	parameter int VALUE_WIDTH = 31
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              job_valid,
	output logic                              job_pop,
	input  logic [VALUE_WIDTH-1:0]            job_number,
	input  itoar_pkg::job_ctl_t               job_ctl,
	input  logic [itoar_pkg::OUT_LW-1:0]      out_level,
	output logic                              out_push,
	output itoar_pkg::out_item_t              out_item
);
	import itoar_pkg::*;

	localparam int STEPS = (VALUE_WIDTH + STEP_BITS - 1) / STEP_BITS;
	localparam int PAD_W = STEPS * STEP_BITS;
	localparam int CW    = $clog2(STEPS);
	localparam int AW    = $clog2(VALUE_WIDTH);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_DIV,
		ST_EMIT
	} state_t;

	state_t             state_q;
	logic [PAD_W-1:0]   div_q;
	logic [RADIX_W-1:0] rem_q;
	logic [RADIX_W-1:0] radix_q;
	logic [CW-1:0]      cnt_q;
	logic [AW-1:0]      wr_ptr_q;
	logic [AW-1:0]      rd_ptr_q;
	logic               vld_s1;
	logic               last_s1;
	logic               bad_s1;
	logic [RADIX_W-1:0] rd_data_s1;
	logic [RADIX_W-1:0] stack_q [VALUE_WIDTH];

	logic [PAD_W-1:0]   div_nx;
	logic [RADIX_W-1:0] rem_nx;
	logic [RADIX_W:0]   trial;
	logic               credit;
	logic               stack_wr;
	logic               stack_rd;

	// Restoring division, STEP_BITS quotient bits per cycle.
	always_comb begin
		div_nx = div_q;
		rem_nx = rem_q;
		trial  = '0;
		for (int i = 0; i < STEP_BITS; i++) begin
			trial  = {rem_nx, div_nx[PAD_W-1]};
			div_nx = {div_nx[PAD_W-2:0], 1'b0};
			if (trial >= {1'b0, radix_q}) begin
				rem_nx    = RADIX_W'(trial - {1'b0, radix_q});
				div_nx[0] = 1'b1;
			end else begin
				rem_nx = trial[RADIX_W-1:0];
			end
		end
	end

	// Room in the result queue, counting the item already in flight.
	assign credit   = (out_level + OUT_LW'(vld_s1)) < OUT_LW'(OUT_DEPTH);
	assign job_pop  = (state_q == ST_IDLE) && job_valid && credit;
	assign stack_wr = (state_q == ST_DIV) && (cnt_q == '0);
	assign stack_rd = (state_q == ST_EMIT) && credit;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			div_q    <= '0;
			rem_q    <= '0;
			radix_q  <= '0;
			cnt_q    <= '0;
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			vld_s1   <= 1'b0;
			last_s1  <= 1'b0;
			bad_s1   <= 1'b0;
		end else begin
			vld_s1 <= 1'b0;
			unique case (state_q)
				ST_IDLE: begin
					if (job_pop) begin
						if (job_ctl.bad) begin
							vld_s1  <= 1'b1;
							last_s1 <= 1'b1;
							bad_s1  <= 1'b1;
						end else begin
							div_q    <= PAD_W'(job_number);
							rem_q    <= '0;
							radix_q  <= job_ctl.radix;
							cnt_q    <= CW'(STEPS - 1);
							wr_ptr_q <= '0;
							state_q  <= ST_DIV;
						end
					end
				end
				ST_DIV: begin
					if (cnt_q == '0) begin
						wr_ptr_q <= wr_ptr_q + 1'b1;
						if (div_nx == '0) begin
							rd_ptr_q <= wr_ptr_q;
							state_q  <= ST_EMIT;
						end else begin
							div_q <= div_nx;
							rem_q <= '0;
							cnt_q <= CW'(STEPS - 1);
						end
					end else begin
						div_q <= div_nx;
						rem_q <= rem_nx;
						cnt_q <= cnt_q - 1'b1;
					end
				end
				ST_EMIT: begin
					if (stack_rd) begin
						vld_s1  <= 1'b1;
						last_s1 <= (rd_ptr_q == '0);
						bad_s1  <= 1'b0;
						if (rd_ptr_q == '0) begin
							state_q <= ST_IDLE;
						end else begin
							rd_ptr_q <= rd_ptr_q - 1'b1;
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Digit stack.
	always_ff @(posedge clk) begin
		if (stack_wr) begin
			stack_q[wr_ptr_q] <= rem_nx;
		end
	end

	always_ff @(posedge clk) begin
		if (stack_rd) begin
			rd_data_s1 <= stack_q[rd_ptr_q];
		end
	end

	assign out_push = vld_s1;

	always_comb begin
		if (bad_s1) begin
			out_item.digit_char = CHAR_NUL;
			out_item.last_digit = 1'b1;
			out_item.bad_radix  = 1'b1;
		end else begin
			out_item.digit_char = digit_to_ascii(rd_data_s1);
			out_item.last_digit = last_s1;
			out_item.bad_radix  = 1'b0;
		end
	end

endmodule

// ===== hdl/integer_to_ascii_radix.sv =====
// ----------------------------------------------------------------------------
// integer_to_ascii_radix
// Converts a non-negative integer to its ASCII digits in a radix of 2 to 36.
// ----------------------------------------------------------------------------
// Both sides look like a queue: write an item with push while full is low,
// take results with pop while empty is low. Each item yields its digits most
// significant first, '0'-'9' then 'A'-'Z', the final one marked by
// last_digit; a zero value gives a single '0', and a radix outside 2..36
// gives a single result with bad_radix set and a NUL character. Only the low
// VALUE_WIDTH bits of number count. Digits come from the shared divider,
// which resolves four quotient bits a cycle, least significant digit first,
// and are read back from the digit stack most significant first. A two-deep
// queue holds arriving items while the divider is busy, and a four-deep
// result queue lets digits wait for the consumer; when it is full, read-back
// from the digit stack waits.
// ----------------------------------------------------------------------------
module integer_to_ascii_radix #(
	parameter int VALUE_WIDTH = 31
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            push,
	output logic                            full,
	input  logic [VALUE_WIDTH-1:0]          number,
	input  logic [itoar_pkg::RADIX_W-1:0]   radix,
	output logic                            empty,
	input  logic                            pop,
	output logic [itoar_pkg::CHAR_W-1:0]    digit_char,
	output logic                            last_digit,
	output logic                            bad_radix
);
	import itoar_pkg::*;

	// Front to back: queued job.
	logic                  job_valid;
	logic                  job_pop;
	logic [VALUE_WIDTH-1:0] job_number;
	job_ctl_t              job_ctl;

	// Back to result queue.
	logic                  out_push;
	out_item_t             out_item;
	out_item_t             out_head;
	logic [OUT_LW-1:0]     out_level;

	// Classify the radix and hold arriving items.
	itoar_front #(
		.VALUE_WIDTH(VALUE_WIDTH)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.full      (full),
		.number    (number),
		.radix     (radix),
		.job_valid (job_valid),
		.job_pop   (job_pop),
		.job_number(job_number),
		.job_ctl   (job_ctl)
	);

	// Divide out digits and stream them back most significant first.
	itoar_back #(
		.VALUE_WIDTH(VALUE_WIDTH)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.job_valid (job_valid),
		.job_pop   (job_pop),
		.job_number(job_number),
		.job_ctl   (job_ctl),
		.out_level (out_level),
		.out_push  (out_push),
		.out_item  (out_item)
	);

	// Hold finished characters until the consumer pops them.
	itoar_fifo #(
		.WIDTH($bits(out_item_t)),
		.DEPTH(OUT_DEPTH)
	) u_out_q (
		.clk   (clk),
		.arst_n(arst_n),
		.push  (out_push),
		.wdata (out_item),
		.pop   (pop),
		.rdata (out_head),
		.empty (empty),
		.level (out_level)
	);

	assign digit_char = out_head.digit_char;
	assign last_digit = out_head.last_digit;
	assign bad_radix  = out_head.bad_radix;

endmodule

// ===== hdl/itoar_checker.sv =====
// ----------------------------------------------------------------------------
// itoar_checker
// Port-level checks on the result side of the radix converter.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module itoar_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       empty,
	input logic       pop,
	input logic [7:0] digit_char,
	input logic       last_digit,
	input logic       bad_radix
);

	// A bad radix result stands alone and carries a NUL character.
	`AST_IMPLY(a_bad_form, clk, arst_n, !empty && bad_radix, (digit_char == 8'h00) && last_digit, "bad radix result malformed")

	// A good result is a digit or an uppercase letter.
	`AST_IMPLY(a_char_range, clk, arst_n, !empty && !bad_radix, ((digit_char >= 8'h30) && (digit_char <= 8'h39)) || ((digit_char >= 8'h41) && (digit_char <= 8'h5A)), "digit character out of range")

	// A waiting result holds until it is taken.
	`AST_NEXT(a_hold, clk, arst_n, !empty && !pop, !empty && $stable(digit_char) && $stable(last_digit) && $stable(bad_radix), "result changed while stalled")

endmodule

bind integer_to_ascii_radix itoar_checker u_itoar_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.empty     (empty),
	.pop       (pop),
	.digit_char(digit_char),
	.last_digit(last_digit),
	.bad_radix (bad_radix)
);

// ===== dv/integer_to_ascii_radix_tb.sv =====
// ----------------------------------------------------------------------------
// integer_to_ascii_radix_tb
// Self-checking bench for the integer to ASCII radix converter. Each item
// is expanded into expected digit characters and compared field by field
// with the results popped from the block.
// ----------------------------------------------------------------------------
// Items are offered with push and taken back with pop, with random idle
// bursts on both sides. The run holds off pop once so that the block backs
// up and raises full, and drains the block once from the sender side. In the
// last part of the run neither side idles.
// ----------------------------------------------------------------------------
module integer_to_ascii_radix_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import itoar_pkg::*;

	localparam int VW             = 31;
	localparam int CLK_HALF       = 5;
	localparam int RANDOM_ITEMS   = 250;
	localparam int TAIL_ITEMS     = 40;     // last items, sent with no idling
	localparam int HOLD_AT        = 40;     // random item where pop holds off
	localparam int PAUSE_AT       = 130;    // random item where push waits for a drain
	localparam int LONG_HOLD      = 250;    // cycles of the long pop hold-off
	localparam int DRAIN_CYCLES   = 400;    // longer than a full base 2 conversion
	localparam int TIMEOUT_CYCLES = 1_000_000;
	localparam int MAX_REPORTS    = 10;

	// How a directed row is checked: by the predictor, by typed-in text,
	// or as a bad radix.
	typedef enum logic [1:0] {
		CHK_MODEL,
		CHK_TEXT,
		CHK_BAD
	} chk_kind_t;

	logic                clk    = 1'b0;
	logic                arst_n = 1'b0;
	logic                push   = 1'b0;
	logic                full;
	logic [VW-1:0]       number = '0;
	logic [RADIX_W-1:0]  radix  = '0;
	logic                empty;
	logic                pop    = 1'b0;
	logic [CHAR_W-1:0]   digit_char;
	logic                last_digit;
	logic                bad_radix;

	// Digit characters still owed by the block, oldest first.
	out_item_t           pending_chars[$];

	// Directed table, one entry per row in each queue.
	logic [VW-1:0]       dir_value[$];
	logic [RADIX_W-1:0]  dir_base[$];
	chk_kind_t           dir_kind[$];
	string               dir_text[$];

	int                  mismatches    = 0;
	int                  items_sent    = 0;
	int                  chars_checked = 0;
	int                  bad_items     = 0;
	int                  zero_items    = 0;
	int                  hold_requests = 0;
	bit                  quiet_tail    = 1'b0;

	integer_to_ascii_radix #(
		.VALUE_WIDTH(VW)
	) u_top (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.full       (full),
		.number     (number),
		.radix      (radix),
		.empty      (empty),
		.pop        (pop),
		.digit_char (digit_char),
		.last_digit (last_digit),
		.bad_radix  (bad_radix)
	);

	always begin
		#CLK_HALF clk = 1'b1;
		#CLK_HALF clk = 1'b0;
	end

	function automatic void report_mismatch(input string msg);
		mismatches++;
		if (mismatches <= MAX_REPORTS) begin
			$display("ERROR @%0t: %s", $time, msg);
		end
	endfunction

	function automatic logic [RADIX_W-1:0] RADIX_WIDTH_LOW(input int unsigned x);
		return x[RADIX_W-1:0];
	endfunction

	// Expand one value into its digit characters in the given base, most
	// significant first, or a bad base into a bad radix item, onto pending_chars.
	function automatic void predict_digits(input logic [VW-1:0] value,
		input logic [RADIX_W-1:0] base);
		logic [CHAR_W-1:0]  rev[0:63];
		logic [VW-1:0]      v;
		logic [RADIX_W-1:0] d;
		out_item_t          ch;
		int                 n;
		if (base < RADIX_MIN || base > RADIX_MAX) begin
			ch.digit_char = CHAR_NUL;
			ch.last_digit = 1'b1;
			ch.bad_radix  = 1'b1;
			pending_chars.push_back(ch);
			return;
		end
		v = value;
		n = 0;
		// collect least significant first; a zero value still gives one digit
		do begin
			d = RADIX_W'(v % base);
			rev[n] = {2'b00, d} + ((d < DEC_BASE) ? CHAR_ZERO : CHAR_A - {2'b00, DEC_BASE});
			n++;
			v = v / base;
		end while (v != '0);
		for (int k = n - 1; k >= 0; k--) begin
			ch.digit_char = rev[k];
			ch.last_digit = (k == 0);
			ch.bad_radix  = 1'b0;
			pending_chars.push_back(ch);
		end
	endfunction

	task automatic add_row(input logic [VW-1:0] value, input logic [RADIX_W-1:0] base,
		input chk_kind_t kind, input string text);
		dir_value.push_back(value);
		dir_base.push_back(base);
		dir_kind.push_back(kind);
		dir_text.push_back(text);
	endtask

	// Offer one item and hold it until the block takes it, then record what
	// it owes. Leave push high; the caller lowers it for a gap.
	task automatic send_item(input logic [VW-1:0] value, input logic [RADIX_W-1:0] base,
		input chk_kind_t kind, input string text);
		out_item_t ch;
		push   <= 1'b1;
		number <= value;
		radix  <= base;
		@(posedge clk);
		while (full) begin
			@(posedge clk);
		end
		items_sent++;
		if (base < RADIX_MIN || base > RADIX_MAX) begin
			bad_items++;
		end else if (value == '0) begin
			zero_items++;
		end
		if (kind == CHK_BAD) begin
			ch.digit_char = CHAR_NUL;
			ch.last_digit = 1'b1;
			ch.bad_radix  = 1'b1;
			pending_chars.push_back(ch);
		end else if (kind == CHK_TEXT) begin
			for (int i = 0; i < text.len(); i++) begin
				ch.digit_char = text[i];
				ch.last_digit = (i == text.len() - 1);
				ch.bad_radix  = 1'b0;
				pending_chars.push_back(ch);
			end
		end else begin
			predict_digits(value, base);
		end
	endtask

	// ------------------------------------------------------------------------
	// Sender: reset, directed table, random items, then drain and verdict.
	// ------------------------------------------------------------------------
	initial begin
		logic [VW-1:0]      value;
		logic [RADIX_W-1:0] base;
		bit                 idle_on;
		int                 no_gap_left;
		int                 sel;

		// Bad radix below and above the valid range, at both field extremes.
		add_row(31'd0,          6'd0,  CHK_BAD,   "");
		add_row(31'd5,          6'd1,  CHK_BAD,   "");
		add_row(31'd100,        6'd37, CHK_BAD,   "");
		add_row(31'h7FFF_FFFF,  6'd63, CHK_BAD,   "");
		// Zero value gives one '0' in any valid base.
		add_row(31'd0,          6'd2,  CHK_TEXT,  "0");
		add_row(31'd0,          6'd10, CHK_TEXT,  "0");
		add_row(31'd0,          6'd36, CHK_TEXT,  "0");
		// Largest value; base 2 gives the longest run.
		add_row(31'h7FFF_FFFF,  6'd2,  CHK_TEXT,  "1111111111111111111111111111111");
		add_row(31'h7FFF_FFFF,  6'd8,  CHK_TEXT,  "17777777777");
		add_row(31'h7FFF_FFFF,  6'd10, CHK_TEXT,  "2147483647");
		add_row(31'h7FFF_FFFF,  6'd16, CHK_TEXT,  "7FFFFFFF");
		// Edges of the letter range and single digits.
		add_row(31'd1,          6'd2,  CHK_TEXT,  "1");
		add_row(31'd9,          6'd10, CHK_TEXT,  "9");
		add_row(31'd10,         6'd11, CHK_TEXT,  "A");
		add_row(31'd35,         6'd36, CHK_TEXT,  "Z");
		add_row(31'd36,         6'd36, CHK_TEXT,  "10");
		// Rest goes through the predictor.
		add_row(31'h5555_5555,  6'd2,  CHK_MODEL, "");
		add_row(31'h2AAA_AAAA,  6'd2,  CHK_MODEL, "");
		add_row(31'h7FFF_FFFF,  6'd3,  CHK_MODEL, "");
		add_row(31'h7FFF_FFFF,  6'd36, CHK_MODEL, "");
		add_row(31'd12345,      6'd7,  CHK_MODEL, "");
		add_row(31'h4000_0000,  6'd35, CHK_MODEL, "");

		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (dir_value[i]) begin
			send_item(dir_value[i], dir_base[i], dir_kind[i], dir_text[i]);
		end

		idle_on     = 1'b1;
		no_gap_left = 0;
		for (int i = 0; i < RANDOM_ITEMS; i++) begin
			// Mostly valid bases, with extra weight on base 2 and base 36.
			sel = $urandom_range(0, 99);
			if (sel < 12) begin
				base = ($urandom_range(0, 2) == 0) ? RADIX_WIDTH_LOW($urandom_range(0, 1))
					: RADIX_WIDTH_LOW($urandom_range(37, 63));
			end else if (sel < 22) begin
				base = RADIX_MIN;
			end else if (sel < 30) begin
				base = RADIX_MAX;
			end else begin
				base = RADIX_WIDTH_LOW($urandom_range(2, 36));
			end
			case ($urandom_range(0, 9))
				0: value = '0;
				1: value = '1;
				2, 3: value = VW'($urandom_range(0, 255));
				4: value = VW'(1) << $urandom_range(0, VW - 1);
				default: value = VW'($urandom());
			endcase

			if (i == HOLD_AT) begin
				// Ask the receiver for a long hold and keep offering items.
				hold_requests <= hold_requests + 1;
				no_gap_left = 12;
			end
			if (i == RANDOM_ITEMS - TAIL_ITEMS) begin
				quiet_tail <= 1'b1;
			end
			if (i % 25 == 0) begin
				idle_on = $urandom_range(0, 1);
			end

			send_item(value, base, CHK_MODEL, "");

			if (i == PAUSE_AT) begin
				// Hold push low until every owed character is back.
				push <= 1'b0;
				while (pending_chars.size() != 0) begin
					@(posedge clk);
				end
			end else if (no_gap_left > 0) begin
				no_gap_left--;
			end else if (idle_on && i < RANDOM_ITEMS - TAIL_ITEMS
				&& $urandom_range(0, 3) == 0) begin
				push <= 1'b0;
				repeat ($urandom_range(1, 10)) @(posedge clk);
			end
		end
		push <= 1'b0;

		while (pending_chars.size() != 0) begin
			@(posedge clk);
		end
		// Catch stray results that would arrive after the last owed one.
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (pending_chars.size() != 0) begin
			report_mismatch($sformatf("%0d characters never arrived", pending_chars.size()));
		end

		$display("Converted %0d items (%0d bad radix, %0d zero values) into %0d characters",
			items_sent, bad_items, zero_items, chars_checked);
		$display("Both sides idled in bursts, pop held off once to back up the block");
		if (mismatches == 0) begin
			$display("SCOREBOARD CLEAN");
		end else begin
			$display("%0d mismatches", mismatches);
			$display("SCOREBOARD MISMATCH");
		end
		$finish;
	end

	// ------------------------------------------------------------------------
	// Receiver: check each popped character, then decide the next pop.
	// ------------------------------------------------------------------------
	initial begin
		out_item_t want;
		int        stall_left;
		int        hold_left;
		int        holds_done;
		stall_left = 0;
		hold_left  = 0;
		holds_done = 0;
		forever begin
			@(posedge clk);
			if (arst_n && pop && !empty) begin
				chars_checked++;
				if (pending_chars.size() == 0) begin
					report_mismatch($sformatf("unexpected character %02h last %0b bad %0b",
						digit_char, last_digit, bad_radix));
				end else begin
					want = pending_chars.pop_front();
					if (digit_char !== want.digit_char || last_digit !== want.last_digit
						|| bad_radix !== want.bad_radix) begin
						report_mismatch($sformatf(
							"char exp %02h got %02h, last exp %0b got %0b, bad exp %0b got %0b",
							want.digit_char, digit_char, want.last_digit, last_digit,
							want.bad_radix, bad_radix));
					end
				end
			end

			// Start a long hold when the sender asks for one.
			if (hold_requests != holds_done) begin
				holds_done++;
				hold_left = LONG_HOLD;
			end
			if (hold_left > 0) begin
				hold_left--;
				pop <= 1'b0;
			end else if (quiet_tail) begin
				pop <= 1'b1;
			end else if (stall_left > 0) begin
				stall_left--;
				pop <= 1'b0;
			end else if ($urandom_range(0, 5) == 0) begin
				stall_left = $urandom_range(1, 10) - 1;
				pop <= 1'b0;
			end else begin
				pop <= 1'b1;
			end
		end
	end

	// Watchdog: stop a hung run.
	initial begin
		#(TIMEOUT_CYCLES * 2 * CLK_HALF);
		$display("Timeout with %0d characters outstanding", pending_chars.size());
		$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule

// ===== sim.f =====
+incdir+hdl
hdl/itoar_pkg.sv
hdl/itoar_fifo.sv
hdl/itoar_front.sv
hdl/itoar_back.sv
hdl/integer_to_ascii_radix.sv
hdl/itoar_checker.sv
dv/integer_to_ascii_radix_tb.sv
